@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
// every check samples on clk and is off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define DQ_NEVER(label, expr, msg) \
  `DQ_ASSERT(label, !(expr), msg)

`endif

@@ rtl/dq_pkg.sv @@
// types, codes and constants of the double-ended queue
// no dependencies
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int ACT_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_LIST_FWD   = 3'd4,
    ACT_LIST_BWD   = 3'd5,
    ACT_COUNT      = 3'd6
  } dq_action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  // request and result payloads
  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [WORD_W-1:0] value;
  } dq_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic [STATUS_W-1:0]      status;
    logic [ENTRIES_W-1:0]     entries;
    logic                     last;
  } dq_out_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       push;
    logic       pop_rd;
    logic       list_first;
    logic       list_next;
    logic       emit_info;
    logic       emit_word;
    dq_status_t status;
    logic       last;
  } dq_cmd_t;

  // datapath to controller
  typedef struct packed {
    dq_action_t act;
    logic       empty;
    logic       full;
    logic       last_idx;
    logic       slot_free;
  } dq_sts_t;

endpackage

@@ rtl/dq_chan_if.sv @@
// valid/ready channel carrying one payload
// payload type given by the instantiating level
`timescale 1ns / 1ps

interface dq_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/dq_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/dq_dp.sv @@
// deque datapath: ring pointers, entry count, list index, store and result register
// depends on dq_pkg and dq_ram
`timescale 1ns / 1ps

module dq_dp #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dq_pkg::dq_in_t  in_data,
  input  dq_pkg::dq_cmd_t cmd,
  output dq_pkg::dq_sts_t sts,
  output logic            out_valid,
  input  logic            out_ready,
  output dq_pkg::dq_out_t out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [PW-1:0]                    front_r, front_nxt, front_inc, front_dec;
  logic [CW-1:0]                    count_r, count_nxt;
  logic [CW-1:0]                    idx_r, idx_nxt, list_idx, list_off, off;
  logic [SW-1:0]                    sum;
  logic [PW-1:0]                    pos_addr, waddr;
  dq_pkg::dq_action_t               act_r;
  logic signed [dq_pkg::WORD_W-1:0] value_r;
  logic [dq_pkg::WORD_W-1:0]        rdata;
  logic                             out_valid_r;
  dq_pkg::dq_out_t                  out_r;
  logic                             slot_free;

  assign front_inc = (front_r == PW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? PW'(DEPTH - 1) : front_r - 1'b1;

  // listing offset, counted from the back when listing backward
  assign list_idx = cmd.list_next ? idx_r + 1'b1 : '0;
  assign list_off = (act_r == dq_pkg::ACT_LIST_FWD) ? list_idx
                                                     : count_r - 1'b1 - list_idx;

  always_comb begin
    if (cmd.push) begin
      off = count_r;
    end else if (cmd.pop_rd) begin
      off = (act_r == dq_pkg::ACT_POP_BACK) ? count_r - 1'b1 : '0;
    end else begin
      off = list_off;
    end
  end

  // ring position: front plus offset, wrapped once
  assign sum      = SW'(front_r) + SW'(off);
  assign pos_addr = (sum >= SW'(DEPTH)) ? PW'(sum - SW'(DEPTH)) : PW'(sum);
  assign waddr    = (act_r == dq_pkg::ACT_PUSH_FRONT) ? front_dec : pos_addr;

  dq_ram #(
    .WIDTH (dq_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (waddr),
    .wdata (value_r),
    .re    (cmd.pop_rd | cmd.list_first | cmd.list_next),
    .raddr (pos_addr),
    .rdata (rdata)
  );

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    if (cmd.push) begin
      count_nxt = count_r + 1'b1;
      if (act_r == dq_pkg::ACT_PUSH_FRONT) begin
        front_nxt = front_dec;
      end
    end else if (cmd.pop_rd) begin
      count_nxt = count_r - 1'b1;
      if (act_r == dq_pkg::ACT_POP_FRONT) begin
        front_nxt = front_inc;
      end
    end
    if (cmd.list_first || cmd.list_next) begin
      idx_nxt = list_idx;
    end
  end

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      act_r       <= dq_pkg::ACT_COUNT;
      out_valid_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (cmd.load) begin
        act_r <= dq_pkg::dq_action_t'(in_data.action);
      end
      if (cmd.emit_info || cmd.emit_word) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_data.value;
    end
    if (cmd.emit_info || cmd.emit_word) begin
      out_r.word    <= cmd.emit_word ? rdata : '0;
      out_r.status  <= cmd.status;
      out_r.entries <= dq_pkg::ENTRIES_W'(count_nxt);
      out_r.last    <= cmd.last;
    end
  end

  assign sts.act       = act_r;
  assign sts.empty     = (count_r == '0);
  assign sts.full      = (count_r >= CW'(DEPTH));
  assign sts.last_idx  = ((idx_r + 1'b1) == count_r);
  assign sts.slot_free = slot_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/dq_ctrl.sv @@
// deque controller: request intake and sequencing of push, pop and listing
// depends on dq_pkg
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dq_pkg::dq_sts_t sts,
  output dq_pkg::dq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_POP,
    S_LIST
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.status = dq_pkg::ST_OK;
    cmd.load   = ready_r && in_valid;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        case (sts.act)
          dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
            if (sts.slot_free) begin
              cmd.emit_info = 1'b1;
              cmd.last      = 1'b1;
              cmd.push      = !sts.full;
              cmd.status    = sts.full ? dq_pkg::ST_FULL : dq_pkg::ST_OK;
              state_nxt     = S_IDLE;
            end
          end
          dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK,
          dq_pkg::ACT_LIST_FWD, dq_pkg::ACT_LIST_BWD: begin
            if (sts.empty) begin
              if (sts.slot_free) begin
                cmd.emit_info = 1'b1;
                cmd.last      = 1'b1;
                cmd.status    = dq_pkg::ST_EMPTY;
                state_nxt     = S_IDLE;
              end
            end else if (sts.act == dq_pkg::ACT_POP_FRONT ||
                         sts.act == dq_pkg::ACT_POP_BACK) begin
              cmd.pop_rd = 1'b1;
              state_nxt  = S_POP;
            end else begin
              cmd.list_first = 1'b1;
              state_nxt      = S_LIST;
            end
          end
          dq_pkg::ACT_COUNT: begin
            if (sts.slot_free) begin
              cmd.emit_info = 1'b1;
              cmd.last      = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          default: begin
            // unused code: dropped without a result
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_POP: begin
        if (sts.slot_free) begin
          cmd.emit_word = 1'b1;
          cmd.last      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_LIST: begin
        if (sts.slot_free) begin
          cmd.emit_word = 1'b1;
          cmd.last      = sts.last_idx;
          if (sts.last_idx) begin
            state_nxt = S_IDLE;
          end else begin
            // fetch the next entry while this one goes out
            cmd.list_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = ready_r;

endmodule

@@ rtl/double_ended_queue_top.sv @@
// channel    dir  handshake      payload
// in_ch      in   valid/ready    action[2:0], value[31:0] signed
// out_ch     out  valid/ready    word[31:0] signed, status[1:0], entries[4:0], last
//
// push, count and every full or empty result are issued from S_OP, the state after S_IDLE
// pop reads the store in S_OP and emits from S_POP: the store has one read port with a registered read
// a listing reads its first entry in S_OP, then one entry leaves per cycle from S_LIST while the result slot is free
// reset clears pointers, count, list index, action and output valid; store words are undefined until pushed
// a held result stalls the controller until the result register is taken
// depends on dq_pkg, dq_chan_if, dq_ctrl, dq_dp, dq_ram, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module double_ended_queue_top #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  dq_chan_if.sink   in_ch,
  dq_chan_if.source out_ch
);

  dq_pkg::dq_cmd_t cmd;
  dq_pkg::dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

  // one request in flight at a time
  `DQ_ASSERT(a_busy_accept, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "accepted while busy")
  // a pending result is never overwritten
  `DQ_NEVER(a_emit_slot, (cmd.emit_info || cmd.emit_word) && !sts.slot_free, "result overwritten")
  `DQ_NEVER(a_no_push_when_full, cmd.push && sts.full, "push into full ring")
  `DQ_NEVER(a_no_pop_when_empty, cmd.pop_rd && sts.empty, "pop from empty ring")

endmodule
